// File: rtl/core/ifdm_pkg.sv
// Shared constants, types and a helper function for the IEEE 754 mantissa/exponent decoder.
// No dependencies.
package ifdm_pkg;

  localparam int unsigned FracW   = 52;  // double fraction width
  localparam int unsigned SglFrW  = 23;  // single fraction width
  localparam int unsigned MagW    = FracW + 1;
  localparam int unsigned MantW   = 54;
  localparam int unsigned ExpW    = 12;
  localparam int unsigned CodeW   = 11;
  localparam int unsigned LzcW    = 6;
  localparam int unsigned SglAlign = FracW - SglFrW;  // left-align single fraction

  localparam logic [ExpW:0] DblBias = 13'd1075;
  localparam logic [ExpW:0] SglBias = 13'd150;

  typedef enum logic {
    FmtDouble = 1'b0,
    FmtSingle = 1'b1
  } fmt_e;

  // Count leading zeros of a 52-bit fraction (all-zero gives 52).
  function automatic logic [LzcW-1:0] lzc_frac(input logic [FracW-1:0] v);
    logic [LzcW-1:0] n;
    n = LzcW'(FracW);
    for (int i = 0; i < FracW; i++) begin
      if (v[i]) n = LzcW'(FracW - 1 - i);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/ieee_float_decode_mant_exp.sv
// IEEE 754 decoder: raw bit pattern to signed integer mantissa and exponent.
// Throughput one per cycle while stall_i does not hold the pipeline.
// Four register stages: capture, field decode and leading-zero count,
// normalising shift and exponent, then sign apply. A stall holds only the
// stages behind a full stage; empty stages keep filling. Reset (rst_ni low,
// asynchronous) clears all stage valid bits; payload registers are not reset.
module ieee_float_decode_mant_exp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   stall_o,
  input  logic                                   func_i,
  input  logic [63:0]                            bits_i,
  output logic                                   valid_o,
  input  logic                                   stall_i,
  output logic signed [ifdm_pkg::MantW-1:0]      mantissa_o,
  output logic signed [ifdm_pkg::ExpW-1:0]       exponent_o
);
  import ifdm_pkg::*;

  // Stage valid bits and per-stage advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // Advance a stage when it is empty or its successor advances
  assign en4 = !v4_q || !stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---- Stage 1: capture the raw transaction
  fmt_e        s1_fmt_q;
  logic [63:0] s1_bits_q;

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      s1_fmt_q  <= fmt_e'(func_i);
      s1_bits_q <= bits_i;
    end
  end

  // ---- Stage 1 -> 2: split fields, left-align the single fraction, count zeros
  logic             s1_sign, s1_zero;
  logic [CodeW-1:0] s1_code;
  logic [FracW-1:0] s1_frac;

  always_comb begin
    if (s1_fmt_q == FmtSingle) begin
      s1_sign = s1_bits_q[31];
      s1_zero = (s1_bits_q[30:0] == 31'd0);
      s1_code = CodeW'(s1_bits_q[30:23]);
      s1_frac = {s1_bits_q[22:0], {SglAlign{1'b0}}};
    end else begin
      s1_sign = s1_bits_q[63];
      s1_zero = (s1_bits_q[62:0] == 63'd0);
      s1_code = s1_bits_q[62:52];
      s1_frac = s1_bits_q[51:0];
    end
  end

  fmt_e             s2_fmt_q;
  logic             s2_sign_q, s2_zero_q, s2_denorm_q;
  logic [CodeW-1:0] s2_code_q;
  logic [FracW-1:0] s2_frac_q;
  logic [LzcW-1:0]  s2_lzc_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      s2_fmt_q    <= s1_fmt_q;
      s2_sign_q   <= s1_sign;
      s2_zero_q   <= s1_zero;
      s2_denorm_q <= (s1_code == '0);
      s2_code_q   <= s1_code;
      s2_frac_q   <= s1_frac;
      s2_lzc_q    <= lzc_frac(s1_frac);
    end
  end

  // ---- Stage 2 -> 3: normalise denormals, form the exponent
  logic [LzcW-1:0] s2_shamt;
  logic [MagW-1:0] s2_mag;
  logic [ExpW:0]   s2_bias, s2_code_eff, s2_exp_wide;

  always_comb begin
    // shift puts the top set fraction bit at the hidden-bit position
    s2_shamt    = s2_lzc_q + LzcW'(1);
    s2_bias     = (s2_fmt_q == FmtSingle) ? SglBias : DblBias;
    if (s2_denorm_q) begin
      s2_mag      = {1'b0, s2_frac_q} << s2_shamt;
      s2_code_eff = (ExpW+1)'(1);
      s2_exp_wide = s2_code_eff - s2_bias - (ExpW+1)'(s2_shamt);
    end else begin
      s2_mag      = {1'b1, s2_frac_q};
      s2_code_eff = (ExpW+1)'(s2_code_q);
      s2_exp_wide = s2_code_eff - s2_bias;
    end
  end

  fmt_e            s3_fmt_q;
  logic            s3_sign_q, s3_zero_q;
  logic [MagW-1:0] s3_mag_q;
  logic [ExpW-1:0] s3_exp_q;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      s3_fmt_q  <= s2_fmt_q;
      s3_sign_q <= s2_sign_q;
      s3_zero_q <= s2_zero_q;
      s3_mag_q  <= s2_mag;
      s3_exp_q  <= s2_exp_wide[ExpW-1:0];
    end
  end

  // ---- Stage 3 -> 4: drop single alignment, apply sign, force zero
  logic [MagW-1:0]  s3_mag_al;
  logic [MantW-1:0] s3_mant;

  always_comb begin
    s3_mag_al = (s3_fmt_q == FmtSingle) ? (s3_mag_q >> SglAlign) : s3_mag_q;
    if (s3_zero_q) begin
      s3_mant = '0;
    end else if (s3_sign_q) begin
      s3_mant = MantW'(0) - {1'b0, s3_mag_al};
    end else begin
      s3_mant = {1'b0, s3_mag_al};
    end
  end

  logic [MantW-1:0] s4_mant_q;
  logic [ExpW-1:0]  s4_exp_q;

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      s4_mant_q <= s3_mant;
      s4_exp_q  <= s3_zero_q ? '0 : s3_exp_q;
    end
  end

  assign valid_o    = v4_q;
  assign mantissa_o = signed'(s4_mant_q);
  assign exponent_o = signed'(s4_exp_q);

endmodule

// File: dv/ieee_float_decode_mant_exp_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ieee_float_decode_mant_exp: directed and random IEEE patterns.
// Depends on ifdm_pkg and the decoder RTL only.
module ieee_float_decode_mant_exp_tb;

  import ifdm_pkg::fmt_e;
  import ifdm_pkg::FmtDouble;
  import ifdm_pkg::FmtSingle;
  import ifdm_pkg::MantW;
  import ifdm_pkg::ExpW;

  // Exponent offsets that turn the stored code into a power of two for the
  // integer mantissa (bias plus fraction width).
  localparam int DblExpOffset = 1075;
  localparam int SglExpOffset = 150;
  localparam int DblFracBits  = 52;
  localparam int SglFracBits  = 23;

  localparam int NumRandom   = 950;
  localparam int IdlePercent = 23;
  localparam int MaxReported = 10;

  typedef struct packed {
    fmt_e        fmt;
    logic [63:0] raw;
  } pattern_t;

  typedef struct packed {
    logic signed [MantW-1:0] mant;
    logic signed [ExpW-1:0]  expo;
  } decoded_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic valid_i = 1'b0;
  logic func_i  = 1'b0;
  logic [63:0] bits_i = '0;
  logic stall_i = 1'b0;
  logic stall_o;
  logic valid_o;
  logic signed [MantW-1:0] mantissa_o;
  logic signed [ExpW-1:0]  exponent_o;

  pattern_t pending_q[$];   // patterns waiting to be offered
  decoded_t decoded_q[$];   // decodes expected from the block, oldest first

  logic in_taken = 1'b0;    // transaction on the input taken at the last rising edge
  int   n_in = 0, n_out = 0, n_single = 0, n_subnormal = 0, n_zero = 0;
  int   n_err = 0;

  ieee_float_decode_mant_exp u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .func_i     (func_i),
    .bits_i     (bits_i),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .mantissa_o (mantissa_o),
    .exponent_o (exponent_o)
  );

  always #6 clk_i = ~clk_i;

  // Decode one raw pattern into mantissa * 2^exponent. Both formats share the
  // same arithmetic once the sign, code and fraction have been picked out.
  function automatic decoded_t decode_pattern(fmt_e fmt, logic [63:0] raw);
    decoded_t    r;
    logic        sgn;
    logic        is_zero;
    int          code;
    int          fw;
    int          offset;
    int          lead;
    int          shift;
    longint      e;
    logic [51:0] frac;
    logic [52:0] mag;
    r = '0;
    if (fmt == FmtSingle) begin
      sgn     = raw[31];
      code    = int'(raw[30:23]);
      frac    = {29'd0, raw[22:0]};
      fw      = SglFracBits;
      offset  = SglExpOffset;
      is_zero = (raw[30:0] == '0);
    end else begin
      sgn     = raw[63];
      code    = int'(raw[62:52]);
      frac    = raw[51:0];
      fw      = DblFracBits;
      offset  = DblExpOffset;
      is_zero = (raw[62:0] == '0);
    end
    if (is_zero) return r;
    if (code != 0) begin
      // normal, infinity or NaN: put the hidden bit in
      mag = {1'b0, frac} | (53'd1 << fw);
      e   = longint'(code - offset);
    end else begin
      // subnormal: shift the top set bit up to the hidden-bit position
      lead = 0;
      for (int i = 0; i < DblFracBits; i++) begin
        if (frac[i]) lead = i;
      end
      shift = fw - lead;
      mag   = {1'b0, frac} << shift;
      e     = longint'(1 - offset - shift);
    end
    r.mant = sgn ? (54'd0 - {1'b0, mag}) : {1'b0, mag};
    r.expo = e[ExpW-1:0];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    n_err++;
    if (n_err <= MaxReported) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic queue_pattern(input fmt_e fmt, input logic [63:0] raw);
    pending_q.push_back('{fmt: fmt, raw: raw});
  endtask

  // Turn idling off for a stretch in the middle of the run so that
  // back-to-back transactions meet an unstalled pipeline.
  function automatic bit calm_stretch();
    return n_in >= 420 && n_in < 600;
  endfunction

  // Driver: change inputs on the falling edge. Hold a payload until the
  // rising edge takes it, then offer the next one or idle at random.
  always @(negedge clk_i) begin : drive_p
    pattern_t nxt;
    bit       calm;
    if (!rst_ni) begin
      valid_i <= 1'b0;
      stall_i <= 1'b0;
    end else begin
      calm = calm_stretch();
      stall_i <= !calm && ($urandom_range(99) < IdlePercent);
      if (!valid_i || in_taken) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
          nxt = pending_q.pop_front();
          valid_i <= 1'b1;
          func_i  <= nxt.fmt;
          bits_i  <= nxt.raw;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: on each rising edge, predict any transaction taken on the input
  // first, then check any transaction leaving the block against the oldest
  // prediction.
  always @(posedge clk_i) begin : watch_p
    decoded_t want;
    in_taken <= rst_ni && valid_i && !stall_o;
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        decoded_q.push_back(decode_pattern(fmt_e'(func_i), bits_i));
        n_in++;
        if (func_i == FmtSingle) begin
          n_single++;
          if (bits_i[30:23] == '0 && bits_i[22:0] != '0) n_subnormal++;
          if (bits_i[30:0] == '0) n_zero++;
        end else begin
          if (bits_i[62:52] == '0 && bits_i[51:0] != '0) n_subnormal++;
          if (bits_i[62:0] == '0) n_zero++;
        end
      end
      if (valid_o && !stall_i) begin
        n_out++;
        if (decoded_q.size() == 0) begin
          flag_error($sformatf("unexpected result mantissa %0d exponent %0d",
                               mantissa_o, exponent_o));
        end else begin
          want = decoded_q.pop_front();
          if (mantissa_o !== want.mant)
            flag_error($sformatf("result %0d: mantissa %0d, expected %0d",
                                 n_out, mantissa_o, want.mant));
          if (exponent_o !== want.expo)
            flag_error($sformatf("result %0d: exponent %0d, expected %0d",
                                 n_out, exponent_o, want.expo));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stim_p
    logic [63:0] raw;
    fmt_e        fmt;
    int          sel;

    // Directed: double precision corners
    queue_pattern(FmtDouble, 64'h0000_0000_0000_0000);  // +0
    queue_pattern(FmtDouble, 64'h8000_0000_0000_0000);  // -0
    queue_pattern(FmtDouble, 64'h3FF0_0000_0000_0000);  // 1.0
    queue_pattern(FmtDouble, 64'hBFF0_0000_0000_0000);  // -1.0
    queue_pattern(FmtDouble, 64'h0000_0000_0000_0001);  // smallest subnormal
    queue_pattern(FmtDouble, 64'h000F_FFFF_FFFF_FFFF);  // largest subnormal
    queue_pattern(FmtDouble, 64'h8000_0000_0001_0000);  // negative subnormal
    queue_pattern(FmtDouble, 64'h0010_0000_0000_0000);  // smallest normal
    queue_pattern(FmtDouble, 64'h7FEF_FFFF_FFFF_FFFF);  // largest normal
    queue_pattern(FmtDouble, 64'hFFEF_FFFF_FFFF_FFFF);  // most negative normal
    queue_pattern(FmtDouble, 64'h7FF0_0000_0000_0000);  // +inf
    queue_pattern(FmtDouble, 64'hFFF0_0000_0000_0000);  // -inf
    queue_pattern(FmtDouble, 64'h7FF8_0000_0000_0001);  // NaN
    queue_pattern(FmtDouble, 64'hFFFF_FFFF_FFFF_FFFF);  // all ones
    // Directed: single precision corners, with junk above bit 31 on some
    queue_pattern(FmtSingle, 64'hDEAD_BEEF_0000_0000);  // +0, upper bits set
    queue_pattern(FmtSingle, 64'h0000_0000_8000_0000);  // -0
    queue_pattern(FmtSingle, 64'h0000_0000_3F80_0000);  // 1.0
    queue_pattern(FmtSingle, 64'hFFFF_FFFF_0000_0001);  // smallest subnormal
    queue_pattern(FmtSingle, 64'h0000_0000_007F_FFFF);  // largest subnormal
    queue_pattern(FmtSingle, 64'h1234_5678_8000_0400);  // negative subnormal
    queue_pattern(FmtSingle, 64'h0000_0000_0080_0000);  // smallest normal
    queue_pattern(FmtSingle, 64'h0000_0000_FF7F_FFFF);  // most negative normal
    queue_pattern(FmtSingle, 64'h0000_0000_7F80_0000);  // +inf
    queue_pattern(FmtSingle, 64'hFFFF_FFFF_FFC0_0001);  // NaN, all upper bits set

    // Random: weight towards subnormals, top codes, zeros and the lowest normal codes, the cases a
    // plain random pattern rarely hits.
    for (int n = 0; n < NumRandom; n++) begin
      fmt = $urandom_range(1) ? FmtSingle : FmtDouble;
      raw = {$urandom(), $urandom()};
      sel = $urandom_range(99);
      if (sel < 40) begin
        // leave fully random
      end else if (sel < 58) begin
        if (fmt == FmtSingle) begin
          raw[30:23] = '0;
          raw[22:0]  = (raw[22:0] | 23'h40_0000) >> $urandom_range(SglFracBits - 1);
        end else begin
          raw[62:52] = '0;
          raw[51:0]  = (raw[51:0] | 52'h8_0000_0000_0000) >> $urandom_range(DblFracBits - 1);
        end
      end else if (sel < 68) begin
        if (fmt == FmtSingle) raw[30:23] = '1;
        else raw[62:52] = '1;
        if ($urandom_range(1)) raw[22:0] = '0;
        if (fmt == FmtDouble && raw[22] == 1'b0) raw[51:0] = '0;
      end else if (sel < 76) begin
        if (fmt == FmtSingle) raw[30:0] = '0;
        else raw[62:0] = '0;
      end else if (sel < 86) begin
        // codes at the bottom of the normal range
        if (fmt == FmtSingle) raw[30:23] = 8'($urandom_range(3, 1));
        else raw[62:52] = 11'($urandom_range(3, 1));
      end
      queue_pattern(fmt, raw);
    end

    // Hold reset low, then release it away from either edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    #3 rst_ni = 1'b1;

    // Drain: wait for every pattern to be taken, then for every decode.
    while (pending_q.size() != 0 || valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (decoded_q.size() != 0)
      flag_error($sformatf("%0d decodes never arrived", decoded_q.size()));

    $display("Decoded %0d patterns (%0d single, %0d double): %0d subnormal, %0d zero.",
             n_in, n_single, n_in - n_single, n_subnormal, n_zero);
    $display("Checked %0d results, %0d mismatches.", n_out, n_err);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (about 1000 transactions,
  // each held up by gaps and stalls on both sides plus the pipeline latency).
  initial begin : watchdog_p
    #(200_000 * 12);
    $display("Timed out with %0d patterns and %0d decodes outstanding.",
             pending_q.size(), decoded_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
